@@ rtl/isrt_pkg.sv @@
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and codes for the interval set range tracker.
// Holds the operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_CLOSE,
    ST_COPY_RD,
    ST_COPY,
    ST_DONE
  } state_t;

endpackage

@@ rtl/isrt_if.sv @@
// ----------------------------------------------------------------------------
// isrt_in_if / isrt_out_if: valid/ready channels of the range tracker.
// One item moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface isrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] range_start;
  logic [31:0] range_end;
  modport source (output valid, operation, range_start, range_end, input ready);
  modport sink (input valid, operation, range_start, range_end, output ready);
endinterface

interface isrt_out_if;
  logic       valid;
  logic       ready;
  logic       covered;
  logic       table_full;
  logic [6:0] interval_count;
  modport source (output valid, covered, table_full, interval_count, input ready);
  modport sink (input valid, covered, table_full, interval_count, output ready);
endinterface

@@ rtl/interval_set_range_tracker.sv @@
// ----------------------------------------------------------------------------
// interval_set_range_tracker: sorted table of disjoint half-open intervals.
//
// The input channel carries an operation (add, remove, query) and a range.
// The output channel returns one item per input: covered, table_full and
// the interval count after the operation. The table lives in two RAMs: the
// live table and a scratch table. The scan reads each live entry (a read
// state, then a scan state, repeated when the entry yields two scratch
// entries) through a shared compare unit and builds the new table in
// scratch. A closing state places the merged add range and decides
// refusal. A copy pass then moves scratch back, entry by entry, through a
// read state and a write state. A query or a refused operation skips the
// copy, as does one that leaves scratch empty; an empty range or an
// unknown code skips the scan and goes straight to the result. A new item
// is taken only once the receiver has taken the result.
// Reset empties the table by clearing the count; no clearing pass is needed.
// The input is not ready while an item is at work or its result waits.
// ----------------------------------------------------------------------------
module interval_set_range_tracker
  import isrt_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS    = 32
) (
  input logic        clk,
  input logic        rst_n,
  isrt_in_if.sink    in_ch,
  isrt_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_INTERVALS + 2);
  localparam int CNTW = $clog2(MAX_INTERVALS + 3);
  localparam int CW = COORD_BITS;
  localparam int MW = 2 * CW;
  localparam int DEPTH = MAX_INTERVALS + 2;

  state_t state_r, state_nxt;

  logic [1:0]      op_r;
  logic [CW-1:0]   lo_r, hi_r, ms_r, me_r;
  logic            placed_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] idx_r;
  logic [CNTW-1:0] sc_r;
  logic            hit_r;
  logic            second_r;
  logic            cov_r, full_r;
  logic            out_valid_r;

  // RAM ports.
  logic          t_we, s_we;
  logic [AW-1:0] t_wa, t_ra, s_wa, s_ra;
  logic [MW-1:0] t_wd, t_rd, s_wd, s_rd;

  isrt_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_table (
    .clk(clk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
    .rd_addr(t_ra), .rd_data(t_rd)
  );

  isrt_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_scratch (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr(s_ra), .rd_data(s_rd)
  );

  // Shared entry unit.
  logic [1:0]    n_emit;
  logic [CW-1:0] s0, e0, s1, e1, ms_o, me_o;
  logic          placed_o, hit;

  isrt_unit #(.CW(CW)) u_unit (
    .op(op_r), .lo(lo_r), .hi(hi_r),
    .s(t_rd[MW-1:CW]), .e(t_rd[CW-1:0]),
    .ms(ms_r), .me(me_r), .placed(placed_r),
    .n_emit(n_emit), .s0(s0), .e0(e0), .s1(s1), .e1(e1),
    .ms_o(ms_o), .me_o(me_o), .placed_o(placed_o), .hit(hit)
  );

  logic            in_fire, out_fire, scan_last, copy_last, refuse;
  logic [CW-1:0]   in_lo, in_hi;
  logic [CNTW-1:0] sc_fin;
  logic            close_we;

  assign in_lo     = CW'(in_ch.range_start);
  assign in_hi     = CW'(in_ch.range_end);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign scan_last = (idx_r + CNTW'(1) >= cnt_r);
  assign copy_last = (idx_r + CNTW'(1) >= sc_r);
  // Final scratch count after the closing placement of an add.
  assign sc_fin    = (op_r == OP_ADD && !placed_r) ? sc_r + CNTW'(1) : sc_r;
  assign refuse    = (sc_fin > CNTW'(MAX_INTERVALS));
  // The merged add range goes last into scratch when nothing followed it.
  assign close_we  = (state_r == ST_CLOSE) && (op_r == OP_ADD) && !placed_r && !refuse;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_lo >= in_hi || in_ch.operation == OP_NOP) begin
            state_nxt = ST_DONE;
          end else if (cnt_r == '0) begin
            state_nxt = ST_CLOSE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (n_emit == 2'd2 && !second_r) begin
          state_nxt = ST_SCAN;
        end else if (scan_last) begin
          state_nxt = ST_CLOSE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_CLOSE: begin
        if (op_r == OP_QUERY || refuse || sc_fin == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: state_nxt = ST_COPY;
      ST_COPY: state_nxt = copy_last ? ST_DONE : ST_COPY_RD;
      ST_DONE: state_nxt = out_fire ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read addresses and writes to RAMs.
  always_comb begin
    t_ra = idx_r[AW-1:0];
    s_ra = idx_r[AW-1:0];
    t_we = 1'b0;
    t_wa = idx_r[AW-1:0];
    t_wd = s_rd;
    s_we = 1'b0;
    s_wa = sc_r[AW-1:0];
    s_wd = {s0, e0};
    case (state_r)
      ST_SCAN: begin
        if (op_r != OP_QUERY && sc_r < CNTW'(DEPTH)) begin
          if (second_r) begin
            s_we = 1'b1;
            s_wd = {s1, e1};
          end else if (n_emit != 2'd0) begin
            s_we = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (close_we) begin
          s_we = 1'b1;
          s_wd = {ms_r, me_r};
        end
      end
      ST_COPY: begin
        t_we = 1'b1;
      end
      default: begin
        t_we = 1'b0;
      end
    endcase
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sc_r        <= '0;
      second_r    <= 1'b0;
      cov_r       <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end else if (state_nxt == ST_DONE && state_r != ST_DONE) begin
        out_valid_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r     <= in_ch.operation;
            lo_r     <= in_lo;
            hi_r     <= in_hi;
            ms_r     <= in_lo;
            me_r     <= in_hi;
            placed_r <= 1'b0;
            idx_r    <= '0;
            sc_r     <= '0;
            second_r <= 1'b0;
            hit_r    <= 1'b0;
            cov_r    <= 1'b0;
            full_r   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (hit) hit_r <= 1'b1;
          if (n_emit == 2'd2 && !second_r) begin
            second_r <= 1'b1;
            sc_r     <= sc_r + 1'b1;
            ms_r     <= ms_o;
            me_r     <= me_o;
            placed_r <= placed_o;
          end else begin
            second_r <= 1'b0;
            if (!second_r) begin
              sc_r     <= sc_r + CNTW'(n_emit);
              ms_r     <= ms_o;
              me_r     <= me_o;
              placed_r <= placed_o;
            end else begin
              sc_r <= sc_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_CLOSE: begin
          // Close the add, decide refusal and prepare the copy pass.
          idx_r <= '0;
          if (op_r == OP_QUERY) begin
            cov_r <= hit_r;
          end else if (refuse) begin
            full_r <= 1'b1;
          end else begin
            sc_r <= sc_fin;
            if (sc_fin == '0) cnt_r <= '0;
          end
        end
        ST_COPY: begin
          idx_r <= idx_r + 1'b1;
          if (copy_last) cnt_r <= sc_r;
        end
        default: begin
          idx_r <= idx_r;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.covered        = cov_r;
  assign out_ch.table_full     = full_r;
  assign out_ch.interval_count = 7'(cnt_r);

endmodule

@@ rtl/isrt_ram.sv @@
// ----------------------------------------------------------------------------
// isrt_ram: generic single-write, single-read RAM.
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module isrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/isrt_unit.sv @@
// ----------------------------------------------------------------------------
// isrt_unit: per-entry interval step shared over the whole scan.
// Classifies one stored interval against the range and yields up to two
// entries to emit, plus the running merge bounds and the query hit.
// ----------------------------------------------------------------------------
module isrt_unit
  import isrt_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic [1:0]    op,
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  input  logic [CW-1:0] s,
  input  logic [CW-1:0] e,
  input  logic [CW-1:0] ms,
  input  logic [CW-1:0] me,
  input  logic          placed,
  output logic [1:0]    n_emit,
  output logic [CW-1:0] s0,
  output logic [CW-1:0] e0,
  output logic [CW-1:0] s1,
  output logic [CW-1:0] e1,
  output logic [CW-1:0] ms_o,
  output logic [CW-1:0] me_o,
  output logic          placed_o,
  output logic          hit
);

  // One entry of the add, remove or query walk.
  always_comb begin
    n_emit   = 2'd0;
    s0       = s;
    e0       = e;
    s1       = s;
    e1       = e;
    ms_o     = ms;
    me_o     = me;
    placed_o = placed;
    hit      = (s <= lo) && (e >= hi);
    case (op)
      OP_ADD: begin
        if (e < lo) begin
          n_emit = 2'd1;
        end else if (s > hi) begin
          if (!placed) begin
            n_emit   = 2'd2;
            s0       = ms;
            e0       = me;
            placed_o = 1'b1;
          end else begin
            n_emit = 2'd1;
          end
        end else begin
          if (s < ms) ms_o = s;
          if (e > me) me_o = e;
        end
      end
      OP_REMOVE: begin
        if (e <= lo || s >= hi) begin
          n_emit = 2'd1;
        end else if (s < lo && e > hi) begin
          n_emit = 2'd2;
          e0     = lo;
          s1     = hi;
        end else if (s < lo) begin
          n_emit = 2'd1;
          e0     = lo;
        end else if (e > hi) begin
          n_emit = 2'd1;
          s0     = hi;
        end
      end
      default: begin
        n_emit = 2'd0;
      end
    endcase
  end

endmodule

@@ sim/tb_interval_set_range_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_interval_set_range_tracker: self-checking bench for the range tracker.
// Drives add, remove and query items with random gaps and receiver stalls,
// predicts every result from a behavioral interval table and compares them.
// ----------------------------------------------------------------------------
module tb_interval_set_range_tracker;
  import isrt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 466;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic       covered;
    logic       table_full;
    logic [6:0] interval_count;
  } tracker_result_t;

  // Behavioral interval table plus the queue of expected results.
  class range_scoreboard;
    logic [31:0] lo_tab[$];
    logic [31:0] hi_tab[$];
    tracker_result_t pending[$];
    int errors;
    int checked;
    int refused;

    // Applies one accepted item to the table and queues its result.
    function void note_item(logic [1:0] op, logic [31:0] lo, logic [31:0] hi);
      logic [31:0] new_lo[$];
      logic [31:0] new_hi[$];
      logic [31:0] ms;
      logic [31:0] me;
      bit placed;
      tracker_result_t r;
      r = '0;
      if (lo < hi) begin
        if (op == OP_ADD) begin
          ms = lo;
          me = hi;
          placed = 0;
          foreach (lo_tab[i]) begin
            if (hi_tab[i] < lo) begin
              new_lo.push_back(lo_tab[i]);
              new_hi.push_back(hi_tab[i]);
            end else if (lo_tab[i] > hi) begin
              if (!placed) begin
                new_lo.push_back(ms);
                new_hi.push_back(me);
                placed = 1;
              end
              new_lo.push_back(lo_tab[i]);
              new_hi.push_back(hi_tab[i]);
            end else begin
              if (lo_tab[i] < ms) ms = lo_tab[i];
              if (hi_tab[i] > me) me = hi_tab[i];
            end
          end
          if (!placed) begin
            new_lo.push_back(ms);
            new_hi.push_back(me);
          end
        end else if (op == OP_REMOVE) begin
          foreach (lo_tab[i]) begin
            if (hi_tab[i] <= lo || lo_tab[i] >= hi) begin
              new_lo.push_back(lo_tab[i]);
              new_hi.push_back(hi_tab[i]);
            end else begin
              if (lo_tab[i] < lo) begin
                new_lo.push_back(lo_tab[i]);
                new_hi.push_back(lo);
              end
              if (hi_tab[i] > hi) begin
                new_lo.push_back(hi);
                new_hi.push_back(hi_tab[i]);
              end
            end
          end
        end else if (op == OP_QUERY) begin
          foreach (lo_tab[i])
            if (lo_tab[i] <= lo && hi_tab[i] >= hi) r.covered = 1'b1;
        end
        if (op == OP_ADD || op == OP_REMOVE) begin
          if (new_lo.size() > TABLE_DEPTH) begin
            r.table_full = 1'b1;
            refused++;
          end else begin
            lo_tab = new_lo;
            hi_tab = new_hi;
          end
        end
      end
      r.interval_count = 7'(lo_tab.size());
      pending.push_back(r);
    endfunction

    // Compares one delivered result with the oldest expectation.
    function void check_result(tracker_result_t got);
      tracker_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.covered !== exp_r.covered) begin
        $display("%0t: covered expected %0b actual %0b", $time, exp_r.covered, got.covered);
        errors++;
      end
      if (got.table_full !== exp_r.table_full) begin
        $display("%0t: table_full expected %0b actual %0b", $time,
                 exp_r.table_full, got.table_full);
        errors++;
      end
      if (got.interval_count !== exp_r.interval_count) begin
        $display("%0t: interval_count expected %0d actual %0d", $time,
                 exp_r.interval_count, got.interval_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  isrt_in_if in_ch ();
  isrt_out_if out_ch ();
  range_scoreboard sb = new();
  bit hold_off = 0;
  int cycle_count = 0;
  int items_sent = 0;

  interval_set_range_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.range_start = '0;
    in_ch.range_end = '0;
    out_ch.ready = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item after a random gap and waits until it is taken.
  // Valid stays high after acceptance until the next call drives it.
  task automatic send_item(logic [1:0] op, logic [31:0] lo, logic [31:0] hi);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.range_start <= lo;
    in_ch.range_end <= hi;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, lo, hi);
    items_sent++;
  endtask

  // Random coordinate: mostly a small window so ranges collide, else anywhere or near the top.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FF00 + $urandom_range(0, 255);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // Receiver: random stalls per item, with one long hold-off.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = $urandom_range(0, 9);
      if ($urandom_range(0, 2) == 0) wait_cycles = 0;
      if (hold_off) wait_cycles = 400;
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result({out_ch.covered, out_ch.table_full, out_ch.interval_count});
    end
  end

  // Stimulus.
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, each operation, empty ranges, touching and split.
    send_item(OP_QUERY, 32'd0, 32'd10);
    send_item(OP_ADD, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'd100, 32'd200);
    send_item(OP_QUERY, 32'd50, 32'd150);
    send_item(OP_ADD, 32'd100, 32'd200);
    send_item(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_ADD, 32'd10, 32'd20);
    send_item(OP_ADD, 32'd20, 32'd30);
    send_item(OP_ADD, 32'd40, 32'd40);
    send_item(OP_ADD, 32'd50, 32'd45);
    send_item(OP_QUERY, 32'd15, 32'd15);
    send_item(OP_QUERY, 32'd10, 32'd30);
    send_item(OP_NOP, 32'hFFFF_FFFF, 32'h5555_AAAA);
    send_item(OP_REMOVE, 32'hAAAA_5555, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
    // Fill the table with the long receiver stall running.
    hold_off = 1;
    for (k = 0; k < 64; k++) begin
      if (k == 2) hold_off = 0;
      send_item(OP_ADD, 32'(k * 4), 32'(k * 4 + 2));
    end
    // Overflow: new entry in a full table, then a trim and a merge.
    send_item(OP_ADD, 32'd1000, 32'd1001);
    send_item(OP_REMOVE, 32'd8, 32'd9);
    send_item(OP_ADD, 32'd2, 32'd4);
    send_item(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
    // Random part.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      a = pick_coord();
      if ($urandom_range(0, 9) == 0) b = pick_coord();
      else b = a + $urandom_range(1, 60);
      if ($urandom_range(0, 99) == 0) send_item(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);
      else if ($urandom_range(0, 29) == 0) send_item(OP_NOP, $urandom(), $urandom());
      else send_item(2'($urandom_range(0, 2)), a, b);
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d refused for a full table.",
             items_sent, sb.checked, sb.refused);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
